@@ rtl/core/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int WordBitsDef = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } rau_kind_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DIV_ZERO = 2'd1,
    STS_BAD_DEN  = 2'd2,
    STS_OVERFLOW = 2'd3
  } rau_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_ADD,
    ST_CHK,
    ST_EVEN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_FIN,
    ST_DONE
  } rau_state_e;

  typedef struct packed {
    logic idle;
    logic done;
  } rau_stat_t;

endpackage

@@ rtl/core/rau_in_if.sv @@
// operand channel: two fractions and an operation
interface rau_in_if #(
  parameter int WordBits = rau_pkg::WordBitsDef
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic signed [WordBits-1:0] a_num;
  logic [WordBits-2:0]        a_den;
  logic signed [WordBits-1:0] b_num;
  logic [WordBits-2:0]        b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ rtl/core/rau_out_if.sv @@
// result channel: reduced fraction and status
interface rau_out_if #(
  parameter int WordBits = rau_pkg::WordBitsDef
);
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] res_num;
  logic [WordBits-2:0]        res_den;
  logic [1:0]                 status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ rtl/core/rau_engine.sv @@
// sequencer with shared multiplier and shared add/subtract unit
module rau_engine #(
  parameter int WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        take_i,
  input  logic [1:0]                  kind_i,
  input  logic signed [WORD_BITS-1:0] a_num_i,
  input  logic [WORD_BITS-2:0]        a_den_i,
  input  logic signed [WORD_BITS-1:0] b_num_i,
  input  logic [WORD_BITS-2:0]        b_den_i,
  output rau_pkg::rau_stat_t          stat_o,
  output logic [WORD_BITS-1:0]        res_num_o,
  output logic [WORD_BITS-2:0]        res_den_o,
  output rau_pkg::rau_status_e        status_o
);
  import rau_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int MW   = 2 * WORD_BITS;
  localparam int CntW = $clog2(MW);
  localparam logic [MW-1:0] HalfRange = MW'(1) << (W - 1);

  rau_state_e state_q, state_d;

  rau_kind_e       kind_q;
  logic            rn_q, s2_q;
  logic [W-1:0]    am_q, bm_q;
  logic [W-2:0]    ad_q, bd_q;
  logic [MW-1:0]   num_q, den_q, gx_q, gy_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    res_num_q;
  logic [W-2:0]    res_den_q;
  rau_status_e     res_sts_q;

  // operand decode at start
  logic [W-1:0] a_raw, b_raw, a_mag, b_mag;
  rau_kind_e    kind_in;
  logic         in_bad_den, in_div_zero;

  // shared units
  logic [W-1:0]  mul_x, mul_y;
  logic [MW-1:0] prod;
  logic [MW:0]   add_a, add_b;
  logic          add_sub;
  logic [MW+1:0] add_full;
  logic          no_borrow;

  logic          last_bit;
  logic [MW-1:0] num_lim;
  logic          ovf;

  assign a_raw       = a_num_i;
  assign b_raw       = b_num_i;
  assign a_mag       = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
  assign b_mag       = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
  assign kind_in     = rau_kind_e'(kind_i);
  assign in_bad_den  = (a_den_i == '0) || (b_den_i == '0);
  assign in_div_zero = (kind_in == KIND_DIV) && (b_raw == '0);

  assign prod      = MW'(mul_x) * MW'(mul_y);
  assign add_full  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (MW+2)'(add_sub);
  assign no_borrow = add_full[MW+1];

  assign last_bit = (cnt_q == CntW'(MW - 1));
  assign num_lim  = HalfRange - MW'(!rn_q);
  assign ovf      = (|den_q[MW-1:W-1]) || (num_q > num_lim);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (in_bad_den || in_div_zero) ? ST_DONE : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        state_d = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? ST_MUL_B : ST_MUL_D;
      end
      ST_MUL_B: state_d = ST_MUL_D;
      ST_MUL_D: begin
        state_d = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? ST_ADD : ST_CHK;
      end
      ST_ADD: begin
        if (rn_q == s2_q || no_borrow) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK:  state_d = (num_q == '0) ? ST_DONE : ST_EVEN;
      ST_EVEN: begin
        if (gx_q[0] || gy_q[0]) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gx_q == '0) begin
          state_d = (gy_q == MW'(1)) ? ST_FIN : ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (last_bit) begin
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (last_bit) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // unit operand selection and status
  always_comb begin
    mul_x       = '0;
    mul_y       = '0;
    add_a       = '0;
    add_b       = '0;
    add_sub     = 1'b0;
    stat_o.idle = 1'b0;
    stat_o.done = 1'b0;
    case (state_q)
      ST_IDLE: stat_o.idle = 1'b1;
      ST_MUL_A: begin
        mul_x = am_q;
        mul_y = (kind_q == KIND_MUL) ? bm_q : {1'b0, bd_q};
      end
      ST_MUL_B: begin
        mul_x = bm_q;
        mul_y = {1'b0, ad_q};
      end
      ST_MUL_D: begin
        mul_x = {1'b0, ad_q};
        mul_y = (kind_q == KIND_DIV) ? bm_q : {1'b0, bd_q};
      end
      ST_ADD: begin
        add_a   = {1'b0, num_q};
        add_b   = {1'b0, gy_q};
        add_sub = (rn_q != s2_q);
      end
      ST_GCD: begin
        add_a   = {1'b0, gx_q};
        add_b   = {1'b0, gy_q};
        add_sub = 1'b1;
      end
      ST_DIVN: begin
        add_a   = {gx_q, num_q[MW-1]};
        add_b   = {1'b0, gy_q};
        add_sub = 1'b1;
      end
      ST_DIVD: begin
        add_a   = {gx_q, den_q[MW-1]};
        add_b   = {1'b0, gy_q};
        add_sub = 1'b1;
      end
      ST_DONE: stat_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_q <= kind_in;
          am_q   <= a_mag;
          bm_q   <= b_mag;
          ad_q   <= a_den_i;
          bd_q   <= b_den_i;
          rn_q   <= (kind_in == KIND_MUL || kind_in == KIND_DIV) ?
                    (a_raw[W-1] ^ b_raw[W-1]) : a_raw[W-1];
          s2_q   <= b_raw[W-1] ^ (kind_in == KIND_SUB);
          res_num_q <= '0;
          res_den_q <= (W-1)'(1);
          if (in_bad_den) begin
            res_sts_q <= STS_BAD_DEN;
          end else if (in_div_zero) begin
            res_sts_q <= STS_DIV_ZERO;
          end else begin
            res_sts_q <= STS_OK;
          end
        end
      end
      ST_MUL_A: num_q <= prod;
      ST_MUL_B: gy_q  <= prod;
      ST_MUL_D: den_q <= prod;
      ST_ADD: begin
        if (rn_q == s2_q || no_borrow) begin
          num_q <= add_full[MW-1:0];
        end else begin
          // smaller minuend: swap terms and subtract next cycle
          num_q <= gy_q;
          gy_q  <= num_q;
          rn_q  <= s2_q;
          s2_q  <= rn_q;
        end
      end
      ST_CHK: begin
        gx_q <= num_q;
        gy_q <= den_q;
      end
      ST_EVEN: begin
        // common powers of two come straight off the fraction
        if (!gx_q[0] && !gy_q[0]) begin
          gx_q  <= gx_q >> 1;
          gy_q  <= gy_q >> 1;
          num_q <= num_q >> 1;
          den_q <= den_q >> 1;
        end
      end
      ST_GCD: begin
        if (gx_q == '0) begin
          cnt_q <= '0;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (no_borrow) begin
          gx_q <= {1'b0, add_full[MW-1:1]};
        end else begin
          gx_q <= gy_q;
          gy_q <= gx_q;
        end
      end
      ST_DIVN: begin
        gx_q  <= no_borrow ? add_full[MW-1:0] : add_a[MW-1:0];
        num_q <= {num_q[MW-2:0], no_borrow};
        cnt_q <= last_bit ? '0 : cnt_q + 1'b1;
      end
      ST_DIVD: begin
        gx_q  <= no_borrow ? add_full[MW-1:0] : add_a[MW-1:0];
        den_q <= {den_q[MW-2:0], no_borrow};
        cnt_q <= last_bit ? '0 : cnt_q + 1'b1;
      end
      ST_FIN: begin
        if (ovf) begin
          res_num_q <= '0;
          res_den_q <= (W-1)'(1);
          res_sts_q <= STS_OVERFLOW;
        end else begin
          res_num_q <= rn_q ? (~num_q[W-1:0] + 1'b1) : num_q[W-1:0];
          res_den_q <= den_q[W-2:0];
          res_sts_q <= STS_OK;
        end
      end
      default: ;
    endcase
  end

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = res_sts_q;

endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// rational arithmetic unit top level with result register
//
//  channel  | dir | handshake     | beat contents
//  ---------+-----+---------------+--------------------------------------------
//  in_i     | in  | valid / ready | kind, a_num, a_den, b_num, b_den
//  out_o    | out | valid / ready | res_num, res_den, status
//
// one item at a time: an input error skips all arithmetic, a zero result
// skips the gcd and division; otherwise the halving and binary gcd steps
// run, then the division steps, which are skipped when the gcd has no odd
// factor above one
// the gcd loop and the division share one add/subtract unit
// reset clears sequencer and result valid; a stalled result waits while the next item runs
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rau_in_if.sink in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  rau_stat_t             stat;
  logic                  take;
  logic [WORD_BITS-1:0]  eng_num;
  logic [WORD_BITS-2:0]  eng_den;
  rau_status_e           eng_sts;

  logic                  out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]  out_num_q;
  logic [WORD_BITS-2:0]  out_den_q;
  rau_status_e           out_sts_q;

  rau_engine #(
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_i.valid),
    .take_i    (take),
    .kind_i    (in_i.kind),
    .a_num_i   (in_i.a_num),
    .a_den_i   (in_i.a_den),
    .b_num_i   (in_i.b_num),
    .b_den_i   (in_i.b_den),
    .stat_o    (stat),
    .res_num_o (eng_num),
    .res_den_o (eng_den),
    .status_o  (eng_sts)
  );

  assign in_i.ready = stat.idle;

  // move the finished result over once the register is free or draining
  assign take = stat.done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_num_q <= eng_num;
      out_den_q <= eng_den;
      out_sts_q <= eng_sts;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = out_num_q;
  assign out_o.res_den = out_den_q;
  assign out_o.status  = out_sts_q;

endmodule

@@ dv/tb_rational_arithmetic_unit.sv @@
// testbench for the rational arithmetic unit: directed table, random operands, predicted results
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int W = WordBitsDef;
  localparam logic signed [W-1:0] NUM_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] NUM_MAX = ~NUM_MIN;
  localparam logic [W-2:0] DEN_MAX = '1;
  localparam int RANDOM_PER_PHASE = 412;
  // longest item: the halving and gcd steps followed by the division steps
  localparam int TAIL_CYCLES = 400;

  typedef struct {
    rau_kind_e              kind;
    logic signed [W-1:0]    a_num;
    logic [W-2:0]           a_den;
    logic signed [W-1:0]    b_num;
    logic [W-2:0]           b_den;
  } frac_op_t;

  typedef struct {
    logic signed [W-1:0]    num;
    logic [W-2:0]           den;
    rau_status_e            status;
  } frac_res_t;

  typedef struct {
    frac_op_t  op;
    bit        typed;
    frac_res_t res;
  } frac_row_t;

  logic clk_i;
  logic rst_ni;

  rau_in_if  #(.WordBits(W)) in_if  ();
  rau_out_if #(.WordBits(W)) out_if ();

  rational_arithmetic_unit #(
    .WORD_BITS(W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frac_res_t pending_results [$];
  frac_row_t stim_table [$];
  int        mismatches = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] magnitude(logic signed [W-1:0] v);
    longint s;
    s = v;
    return (s < 0) ? 64'(-s) : 64'(s);
  endfunction

  // exact fraction arithmetic followed by sign fix-up, gcd reduction and status checks
  function automatic frac_res_t reduce_fraction(frac_op_t op);
    logic [63:0] am, bm, ad, bd, m1, m2, rm, rd, x, y, t, nm;
    logic [63:0] sign_lim, den_lim;
    logic        an, bn, n2, rn;
    rau_status_e sts;
    frac_res_t   res;
    sign_lim = 64'd1 << (W - 1);
    den_lim  = sign_lim - 64'd1;
    an = op.a_num[W-1];
    bn = op.b_num[W-1];
    am = magnitude(op.a_num);
    bm = magnitude(op.b_num);
    ad = 64'(op.a_den);
    bd = 64'(op.b_den);
    rn = 1'b0;
    rm = 64'd0;
    rd = 64'd1;
    sts = STS_OK;
    if (ad == 64'd0 || bd == 64'd0) begin
      sts = STS_BAD_DEN;
    end else if (op.kind == KIND_DIV && bm == 64'd0) begin
      sts = STS_DIV_ZERO;
    end else begin
      case (op.kind)
        KIND_ADD, KIND_SUB: begin
          m1 = am * bd;
          m2 = bm * ad;
          n2 = (op.kind == KIND_SUB) ? !bn : bn;
          if (an == n2) begin
            rn = an;
            rm = m1 + m2;
          end else if (m1 >= m2) begin
            rn = an;
            rm = m1 - m2;
          end else begin
            rn = n2;
            rm = m2 - m1;
          end
          rd = ad * bd;
        end
        KIND_MUL: begin
          rn = an ^ bn;
          rm = am * bm;
          rd = ad * bd;
        end
        default: begin
          rn = an ^ bn;
          rm = am * bd;
          rd = ad * bm;
        end
      endcase
      if (rm == 64'd0) begin
        rn = 1'b0;
        rd = 64'd1;
      end else begin
        x = rm;
        y = rd;
        while (y != 64'd0) begin
          t = x % y;
          x = y;
          y = t;
        end
        rm = rm / x;
        rd = rd / x;
        if (rd > den_lim || rm > sign_lim || (!rn && rm == sign_lim)) sts = STS_OVERFLOW;
      end
    end
    if (sts != STS_OK) begin
      rn = 1'b0;
      rm = 64'd0;
      rd = 64'd1;
    end
    nm = rn ? -rm : rm;
    res.num    = nm[W-1:0];
    res.den    = rd[W-2:0];
    res.status = sts;
    return res;
  endfunction

  function automatic logic signed [W-1:0] rand_num();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 200)) - 100;
      3, 4:    v = $urandom;
      5: begin
        case ($urandom_range(0, 4))
          0:       v = NUM_MIN;
          1:       v = NUM_MAX;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      6: v = $urandom_range(0, 65535);
      7, 8: v = $urandom_range(1, 30) * $urandom_range(1, 1000);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (v > 0 && $urandom_range(0, 1)) v = -v;
    return v[W-1:0];
  endfunction

  // a zero denominator turns up now and then, most operands are well formed
  function automatic logic [W-2:0] rand_den();
    logic [31:0] d;
    case ($urandom_range(0, 31))
      0:                  d = 32'd0;
      1, 2, 3, 4, 5,
      6, 7, 8, 9, 10:     d = $urandom_range(1, 100);
      11, 12, 13, 14,
      15, 16:             d = $urandom;
      17, 18:             d = $urandom_range(0, 1) ? 32'(DEN_MAX) : 32'd1;
      19, 20, 21, 22,
      23, 24:             d = $urandom_range(1, 65535);
      default:            d = $urandom_range(1, 40) * $urandom_range(1, 40);
    endcase
    return d[W-2:0];
  endfunction

  task automatic add_row(input rau_kind_e k, input logic signed [W-1:0] an,
                         input logic [W-2:0] ad, input logic signed [W-1:0] bn,
                         input logic [W-2:0] bd, input bit typed,
                         input logic signed [W-1:0] en, input logic [W-2:0] ed,
                         input rau_status_e es);
    frac_row_t r;
    r.op.kind  = k;
    r.op.a_num = an;
    r.op.a_den = ad;
    r.op.b_num = bn;
    r.op.b_den = bd;
    r.typed    = typed;
    r.res.num    = en;
    r.res.den    = ed;
    r.res.status = es;
    stim_table.push_back(r);
  endtask

  task automatic send_op(input frac_op_t op, input frac_res_t want);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= op.kind;
    in_if.a_num <= op.a_num;
    in_if.a_den <= op.a_den;
    in_if.b_num <= op.b_num;
    in_if.b_den <= op.b_den;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(want);
  endtask

  // result side: random back-pressure and in-order checking
  always @(posedge clk_i) begin
    frac_res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding: %0d/%0d status %0d",
                 out_if.res_num, out_if.res_den, out_if.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.res_num !== want.num) begin
            $error("res_num: expected %0d, got %0d", want.num, out_if.res_num);
            mismatches++;
          end
          if (out_if.res_den !== want.den) begin
            $error("res_den: expected %0d, got %0d", want.den, out_if.res_den);
            mismatches++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin
    frac_op_t op;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_ADD;
    in_if.a_num  <= '0;
    in_if.a_den  <= '0;
    in_if.b_num  <= '0;
    in_if.b_den  <= '0;

    add_row(KIND_ADD, 1, 2, 1, 3, 1, 5, 6, STS_OK);
    add_row(KIND_SUB, 1, 2, 1, 2, 1, 0, 1, STS_OK);
    add_row(KIND_MUL, 0, 5, 7, 3, 1, 0, 1, STS_OK);
    add_row(KIND_DIV, 1, 2, 0, 1, 1, 0, 1, STS_DIV_ZERO);
    add_row(KIND_ADD, 1, 0, 1, 1, 1, 0, 1, STS_BAD_DEN);
    // zero denominator wins over division by zero
    add_row(KIND_DIV, 1, 1, 0, 0, 1, 0, 1, STS_BAD_DEN);
    add_row(KIND_MUL, 5, 7, 3, 0, 1, 0, 1, STS_BAD_DEN);
    add_row(KIND_SUB, 0, 0, 0, 0, 1, 0, 1, STS_BAD_DEN);
    add_row(KIND_MUL, NUM_MAX, 1, NUM_MAX, 1, 1, 0, 1, STS_OVERFLOW);
    add_row(KIND_MUL, NUM_MIN, 1, 1, 1, 1, NUM_MIN, 1, STS_OK);
    add_row(KIND_MUL, NUM_MIN, 1, -1, 1, 1, 0, 1, STS_OVERFLOW);
    add_row(KIND_DIV, 1, DEN_MAX, NUM_MAX, 1, 1, 0, 1, STS_OVERFLOW);
    add_row(KIND_SUB, NUM_MAX, 1, NUM_MIN, 1, 1, 0, 1, STS_OVERFLOW);
    add_row(KIND_ADD, NUM_MIN, 1, -1, 1, 1, 0, 1, STS_OVERFLOW);
    add_row(KIND_ADD, NUM_MAX, 1, 0, 1, 1, NUM_MAX, 1, STS_OK);
    // operands not in lowest terms, cancellation and extreme operands
    add_row(KIND_ADD, 2, 4, 3, 6, 1, 1, 1, STS_OK);
    add_row(KIND_DIV, 3, 4, -3, 8, 1, -2, 1, STS_OK);
    add_row(KIND_MUL, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX, 1, 1, 1, STS_OK);
    add_row(KIND_ADD, 1, DEN_MAX, -1, DEN_MAX, 1, 0, 1, STS_OK);
    add_row(KIND_SUB, -1, 1, 1, 1, 1, -2, 1, STS_OK);
    add_row(KIND_DIV, NUM_MIN, 1, NUM_MIN, 1, 1, 1, 1, STS_OK);
    add_row(KIND_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX - 1, 0, 0, 0, STS_OK);
    add_row(KIND_DIV, NUM_MIN, DEN_MAX, 1, DEN_MAX, 0, 0, 0, STS_OK);
    add_row(KIND_SUB, 1234567, 7654321, -89, 360, 0, 0, 0, STS_OK);
    add_row(KIND_MUL, 123456789, 1000, -4000, 987654321, 0, 0, 0, STS_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_op(stim_table[i].op,
              stim_table[i].typed ? stim_table[i].res : reduce_fraction(stim_table[i].op));
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        op.kind  = rau_kind_e'($urandom_range(0, 3));
        op.a_num = rand_num();
        op.a_den = rand_den();
        op.b_num = rand_num();
        op.b_den = rand_den();
        send_op(op, reduce_fraction(op));
      end
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
